### rtl/core/compass_heading_autocal_top_macros.svh
// ----------------------------------------------------------------------------
// compass_heading_autocal_top_macros.svh
// Assertion shorthands shared by the compass heading modules.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_AUTOCAL_TOP_MACROS_SVH
`define COMPASS_HEADING_AUTOCAL_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CHA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// Shared types and constants of the compass heading block.
// ----------------------------------------------------------------------------
package cha_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int HEADING_BITS     = 16;
    localparam int DECL_BITS        = 16;
    localparam int ANGLE_BITS       = 32;
    localparam int VEC_BITS         = 64;
    localparam int NORM_MSB         = 59;
    localparam int COARSE_SHIFT     = 8;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER  = 32'h4000_0000;
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF     = 32'h8000_0000;
    localparam logic [ANGLE_BITS-1:0] ANGLE_3QUARTER = 32'hC000_0000;
    localparam logic [HEADING_BITS-1:0] HEADING_SCALE = 16'd36000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CAL_ENABLE  = 1'b0,
        CFG_DECLINATION = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_UPDATE,
        OP_PREP,
        OP_MUL,
        OP_MAG,
        OP_NORM,
        OP_PRE,
        OP_ITER,
        OP_DECL,
        OP_SCALE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cha_cmd_t;

    typedef struct packed {
        logic special;
        logic norm_done;
        logic iter_last;
    } cha_stat_t;

endpackage

### rtl/core/cha_ctrl.sv
// ----------------------------------------------------------------------------
// cha_ctrl
// Sequencer of the compass heading block: steps the datapath through
// calibration, scaling, normalization, CORDIC, declination, output hand-off.
// ----------------------------------------------------------------------------
`include "compass_heading_autocal_top_macros.svh"

module cha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cha_pkg::cha_cmd_t   cmd,
    input  cha_pkg::cha_stat_t  stat
);
    import cha_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_MUL,
        ST_MAG,
        ST_NORM,
        ST_PRE,
        ST_ITER,
        ST_DECL,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd          = '{op: OP_IDLE, out_load: 1'b0};
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = stat.special ? ST_DECL : ST_NORM;
            end
            ST_NORM:
            begin
                cmd.op     = OP_NORM;
                state_next = stat.norm_done ? ST_PRE : ST_NORM;
            end
            ST_PRE:
            begin
                cmd.op     = OP_PRE;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.op     = OP_ITER;
                state_next = stat.iter_last ? ST_DECL : ST_ITER;
            end
            ST_DECL:
            begin
                cmd.op     = OP_DECL;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `CHA_ASSERT(a_accept_starts_update, (s_tvalid && s_tready) |=> (state_reg == ST_UPDATE), "accepted beat did not start calibration update")
    `CHA_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_reg && !m_tready, "output register overwritten while a beat waits")
    `CHA_ASSERT(a_iter_holds, (state_reg == ST_ITER && !stat.iter_last) |=> (state_reg == ST_ITER), "CORDIC left before its last step")

endmodule

### rtl/core/cha_dpath.sv
// ----------------------------------------------------------------------------
// cha_dpath
// Datapath of the compass heading block: min/max tracking, span scaling,
// normalizing shifter, shared CORDIC shift-add stage and degree scaling.
// ----------------------------------------------------------------------------
`include "compass_heading_autocal_top_macros.svh"

module cha_dpath #(
    parameter int SAMPLE_BITS  = cha_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = cha_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [SAMPLE_BITS-1:0]        in_x,
    input  logic signed [SAMPLE_BITS-1:0]        in_y,
    input  logic                                 in_clear,
    input  logic                                 cal_enable,
    input  logic signed [cha_pkg::DECL_BITS-1:0] declination,
    input  cha_pkg::cha_cmd_t                    cmd,
    output cha_pkg::cha_stat_t                   stat,
    output logic [cha_pkg::HEADING_BITS-1:0]     heading,
    output logic                                 calibrated
);
    import cha_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int DW     = SB + 2;
    localparam int SW     = SB + 1;
    localparam int PW     = DW + SW;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int PROD_W = ANGLE_BITS + HEADING_BITS;

    logic signed [SB-1:0]       x_reg, y_reg;
    logic                       clear_reg;
    logic signed [SB-1:0]       x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic signed [SB-1:0]       x_low_next, x_high_next, y_low_next, y_high_next;
    logic signed [SB-1:0]       x_low_base, x_high_base, y_low_base, y_high_base;
    logic signed [DW-1:0]       dx_reg, dy_reg;
    logic signed [SW-1:0]       spx_reg, spy_reg;
    logic                       cal_reg;
    logic signed [PW-1:0]       px, py;
    logic signed [VEC_BITS-1:0] vx_reg, vy_reg;
    logic signed [VEC_BITS-1:0] ax, ay, shx, shy;
    logic [VEC_BITS-1:0]        m_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [ANGLE_BITS-1:0]      z_reg;
    logic [PROD_W-1:0]          prod;
    logic [HEADING_BITS-1:0]    head_reg;
    logic [HEADING_BITS-1:0]    out_heading_reg;
    logic                       out_cal_reg;
    logic                       coarse;
    logic                       y_pos;

    // clear acts before the sample widens the range
    always_comb
    begin
        x_low_base  = clear_reg ? '0 : x_low_reg;
        x_high_base = clear_reg ? '0 : x_high_reg;
        y_low_base  = clear_reg ? '0 : y_low_reg;
        y_high_base = clear_reg ? '0 : y_high_reg;
        x_low_next  = x_low_base;
        x_high_next = x_high_base;
        y_low_next  = y_low_base;
        y_high_next = y_high_base;
        if (cal_enable)
        begin
            if (x_reg < x_low_base)
            begin
                x_low_next = x_reg;
            end
            else if (x_reg > x_high_base)
            begin
                x_high_next = x_reg;
            end
            if (y_reg < y_low_base)
            begin
                y_low_next = y_reg;
            end
            else if (y_reg > y_high_base)
            begin
                y_high_next = y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= '0;
            x_high_reg <= '0;
            y_low_reg  <= '0;
            y_high_reg <= '0;
        end
        else if (cmd.op == OP_UPDATE)
        begin
            x_low_reg  <= x_low_next;
            x_high_reg <= x_high_next;
            y_low_reg  <= y_low_next;
            y_high_reg <= y_high_next;
        end
    end

    assign px     = dx_reg * spy_reg;
    assign py     = dy_reg * spx_reg;
    assign ax     = vx_reg[VEC_BITS-1] ? -vx_reg : vx_reg;
    assign ay     = vy_reg[VEC_BITS-1] ? -vy_reg : vy_reg;
    assign coarse = (m_reg[VEC_BITS-1:NORM_MSB-COARSE_SHIFT+1] == '0);
    assign shx    = vx_reg >>> step_reg;
    assign shy    = vy_reg >>> step_reg;
    assign y_pos  = !vy_reg[VEC_BITS-1] && (vy_reg != '0);
    assign prod   = PROD_W'(z_reg) * PROD_W'(HEADING_SCALE);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                x_reg     <= in_x;
                y_reg     <= in_y;
                clear_reg <= in_clear;
            end
            OP_PREP:
            begin
                cal_reg <= (x_low_reg != x_high_reg) && (y_low_reg != y_high_reg);
                dx_reg  <= (DW'(x_reg) <<< 1) - (DW'(x_high_reg) + DW'(x_low_reg));
                dy_reg  <= (DW'(y_reg) <<< 1) - (DW'(y_high_reg) + DW'(y_low_reg));
                spx_reg <= SW'(x_high_reg) - SW'(x_low_reg);
                spy_reg <= SW'(y_high_reg) - SW'(y_low_reg);
            end
            OP_MUL:
            begin
                if (cal_reg)
                begin
                    vx_reg <= VEC_BITS'(px);
                    vy_reg <= VEC_BITS'(py);
                end
                else
                begin
                    vx_reg <= VEC_BITS'(x_reg);
                    vy_reg <= VEC_BITS'(y_reg);
                end
            end
            OP_MAG:
            begin
                m_reg <= (ax > ay) ? ax : ay;
                // zero vector and axis-aligned vectors skip the CORDIC
                if (vy_reg == '0)
                begin
                    z_reg <= vx_reg[VEC_BITS-1] ? ANGLE_HALF : '0;
                end
                else if (vx_reg == '0)
                begin
                    z_reg <= vy_reg[VEC_BITS-1] ? ANGLE_3QUARTER : ANGLE_QUARTER;
                end
            end
            OP_NORM:
            begin
                if (!stat.norm_done)
                begin
                    if (coarse)
                    begin
                        vx_reg <= vx_reg <<< COARSE_SHIFT;
                        vy_reg <= vy_reg <<< COARSE_SHIFT;
                        m_reg  <= m_reg << COARSE_SHIFT;
                    end
                    else
                    begin
                        vx_reg <= vx_reg <<< 1;
                        vy_reg <= vy_reg <<< 1;
                        m_reg  <= m_reg << 1;
                    end
                end
            end
            OP_PRE:
            begin
                step_reg <= '0;
                if (vx_reg[VEC_BITS-1])
                begin
                    vx_reg <= -vx_reg;
                    vy_reg <= -vy_reg;
                    z_reg  <= ANGLE_HALF;
                end
                else
                begin
                    z_reg <= '0;
                end
            end
            OP_ITER:
            begin
                step_reg <= step_reg + 1'b1;
                if (y_pos)
                begin
                    vx_reg <= vx_reg + shy;
                    vy_reg <= vy_reg - shx;
                    z_reg  <= z_reg + ATAN_TAB[5'(step_reg)];
                end
                else
                begin
                    vx_reg <= vx_reg - shy;
                    vy_reg <= vy_reg + shx;
                    z_reg  <= z_reg - ATAN_TAB[5'(step_reg)];
                end
            end
            OP_DECL:
            begin
                z_reg <= z_reg + {declination, {(ANGLE_BITS-DECL_BITS){1'b0}}};
            end
            OP_SCALE:
            begin
                head_reg <= prod[PROD_W-1:ANGLE_BITS];
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_heading_reg <= head_reg;
            out_cal_reg     <= cal_reg;
        end
    end

    assign stat.special   = (vx_reg == '0) || (vy_reg == '0);
    assign stat.norm_done = (m_reg[VEC_BITS-1:NORM_MSB] != '0);
    assign stat.iter_last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    assign heading    = out_heading_reg;
    assign calibrated = out_cal_reg;

    `CHA_ASSERT(a_range_spans_zero, (x_low_reg <= 0) && (x_high_reg >= 0) && (y_low_reg <= 0) && (y_high_reg >= 0), "min/max no longer bracket zero")
    `CHA_ASSERT(a_norm_window, (cmd.op == OP_PRE) |-> (m_reg[VEC_BITS-1:NORM_MSB+1] == '0), "normalized magnitude above window")
    `CHA_ASSERT(a_heading_range, cmd.out_load |=> (out_heading_reg < HEADING_SCALE), "heading beyond one turn")

endmodule

### rtl/core/compass_heading_autocal_top.sv
// ----------------------------------------------------------------------------
// compass_heading_autocal_top
// Compass heading from raw X/Y magnetometer samples with running min/max
// hard-iron calibration, CORDIC atan2 and declination offset.
//
//   channel  dir  beat contents
//   s_axis   in   tdata: mag_x, mag_y    tuser: clear_calibration
//   m_axis   out  tdata: heading_centideg tuser: calibrated
//   cfg      in   0 calibration_enable, 1 declination_offset
//
// One sample runs from accept to result through load, calibration update,
// span preparation, multiply, magnitude, the normalizing shifter, CORDIC
// pre-rotation, the shared CORDIC shift-add stage, declination and degree
// scaling. Zero and axis-aligned vectors skip the shifter and the CORDIC.
// Reset clears the min/max registers and sets calibration on at once.
// A finished result waits in the output register while the next sample
// is taken; a stalled output holds the sequencer only at its last step.
// ----------------------------------------------------------------------------
module compass_heading_autocal_top #(
    parameter int SAMPLE_BITS  = cha_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = cha_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // mag_x, mag_y from the lowest bit up, zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    // clear_calibration
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // heading_centideg
    output logic [cha_pkg::HEADING_BITS-1:0]         m_tdata,
    // calibrated
    output logic                                     m_tuser,
    input  logic                                     cfg_we,
    input  logic [cha_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [cha_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
    import cha_pkg::*;

    logic                        cal_en_reg;
    logic signed [DECL_BITS-1:0] decl_reg;
    cha_cmd_t                    cmd;
    cha_stat_t                   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_en_reg <= 1'b1;
            decl_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CAL_ENABLE:  cal_en_reg <= cfg_data[0];
                CFG_DECLINATION: decl_reg   <= cfg_data[DECL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cha_dpath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_x        (s_tdata[SAMPLE_BITS-1:0]),
        .in_y        (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_clear    (s_tuser),
        .cal_enable  (cal_en_reg),
        .declination (decl_reg),
        .cmd         (cmd),
        .stat        (stat),
        .heading     (m_tdata),
        .calibrated  (m_tuser)
    );

endmodule
